// ----- sv/timer_socket_relay_controller_defines.svh -----
// ----------------------------------------------------------------------------
// timer socket relay controller assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef TIMER_SOCKET_RELAY_CONTROLLER_DEFINES_SVH
`define TIMER_SOCKET_RELAY_CONTROLLER_DEFINES_SVH

// condition implies consequence in the same cycle
`define TSR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the following cycle
`define TSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tsr_pkg.sv -----
// ----------------------------------------------------------------------------
// tsr_pkg
// types, codes and time helpers for the timer socket relay controller
// ----------------------------------------------------------------------------
`default_nettype none

package tsr_pkg;

    // time constants
    localparam int unsigned SEC_PER_HOUR  = 3600;
    localparam int unsigned SEC_PER_MIN   = 60;
    localparam int unsigned HOURS_PER_DAY = 24;
    localparam int unsigned MIN_PER_HOUR  = 60;
    localparam int unsigned SEC_WIDTH     = 17;

    // transaction kinds
    typedef enum logic [2:0] {
        KIND_KEY     = 3'd0,
        KIND_TICK    = 3'd1,
        KIND_SET_NOW = 3'd2,
        KIND_SET_ON  = 3'd3,
        KIND_SET_OFF = 3'd4,
        KIND_REMOTE  = 3'd5
    } kind_t;

    // ui modes
    typedef enum logic [2:0] {
        MODE_MAIN   = 3'd0,
        MODE_SSID   = 3'd1,
        MODE_PASS   = 3'd2,
        MODE_STATUS = 3'd3,
        MODE_TIMER  = 3'd4
    } mode_t;

    // key codes
    localparam logic [2:0] KEY_1 = 3'd1;
    localparam logic [2:0] KEY_2 = 3'd2;
    localparam logic [2:0] KEY_3 = 3'd3;
    localparam logic [2:0] KEY_4 = 3'd4;
    localparam logic [2:0] KEY_5 = 3'd5;

    // row and digit selections
    localparam logic [1:0] ROW_CURRENT  = 2'd0;
    localparam logic [1:0] ROW_ON       = 2'd1;
    localparam logic [1:0] ROW_OFF      = 2'd2;
    localparam logic [1:0] DIGIT_HOUR   = 2'd0;
    localparam logic [1:0] DIGIT_MINUTE = 2'd1;
    localparam logic [1:0] SEL_COUNT    = 2'd3;

    // time of day held as separate units, hour in the top bits
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } tsr_time_t;

    localparam tsr_time_t RESET_ON_TIME  = '{hour: 5'd8,  minute: 6'd0, second: 6'd0};
    localparam tsr_time_t RESET_OFF_TIME = '{hour: 5'd22, minute: 6'd0, second: 6'd0};

    // one input transaction
    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] key_number;
        logic [7:0] hour_value;
        logic [7:0] minute_value;
        logic [7:0] second_value;
        logic [2:0] field_present;
        logic       relay_request;
    } tsr_item_t;

    // controller state
    typedef struct packed {
        mode_t      mode;
        logic       relay;
        logic [1:0] row;
        logic [1:0] digit;
        tsr_time_t  now;
        tsr_time_t  on_time;
        tsr_time_t  off_at;
    } tsr_state_t;

    // outcome of one step
    typedef struct packed {
        tsr_state_t            state;
        logic                  clock_write;
        logic [SEC_WIDTH-1:0]  on_seconds;
        logic [SEC_WIDTH-1:0]  off_seconds;
    } tsr_result_t;

    // byte modulo 24 by restoring subtraction of 8, 4, 2 and 1 times 24
    function automatic logic [4:0] mod_hours(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if (r >= 8'd192) r = r - 8'd192;
        if (r >= 8'd96)  r = r - 8'd96;
        if (r >= 8'd48)  r = r - 8'd48;
        if (r >= 8'd24)  r = r - 8'd24;
        return r[4:0];
    endfunction

    // byte modulo 60 by subtraction of 4, 2 and 1 times 60
    function automatic logic [5:0] mod_sixty(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if (r >= 8'd240) r = r - 8'd240;
        if (r >= 8'd120) r = r - 8'd120;
        if (r >= 8'd60)  r = r - 8'd60;
        return r[5:0];
    endfunction

    // hour up or down with wrap
    function automatic logic [4:0] step_hour(input logic [4:0] h, input logic up);
        logic [4:0] r;
        if (up)
            r = (h == 5'(HOURS_PER_DAY - 1)) ? 5'd0 : h + 5'd1;
        else
            r = (h == 5'd0) ? 5'(HOURS_PER_DAY - 1) : h - 5'd1;
        return r;
    endfunction

    // minute or second up or down with wrap
    function automatic logic [5:0] step_sixty(input logic [5:0] v, input logic up);
        logic [5:0] r;
        if (up)
            r = (v == 6'(MIN_PER_HOUR - 1)) ? 6'd0 : v + 6'd1;
        else
            r = (v == 6'd0) ? 6'(MIN_PER_HOUR - 1) : v - 6'd1;
        return r;
    endfunction

    // step the selected unit; an unused digit code acts as the second
    function automatic tsr_time_t step_time(input tsr_time_t t, input logic [1:0] digit,
                                            input logic up);
        tsr_time_t r;
        r = t;
        case (digit)
            DIGIT_HOUR:   r.hour   = step_hour(t.hour, up);
            DIGIT_MINUTE: r.minute = step_sixty(t.minute, up);
            default:      r.second = step_sixty(t.second, up);
        endcase
        return r;
    endfunction

    // replace the units flagged present
    function automatic tsr_time_t merge_units(input tsr_time_t t, input tsr_item_t it);
        tsr_time_t r;
        r = t;
        if (it.field_present[0]) r.hour   = mod_hours(it.hour_value);
        if (it.field_present[1]) r.minute = mod_sixty(it.minute_value);
        if (it.field_present[2]) r.second = mod_sixty(it.second_value);
        return r;
    endfunction

    // seconds since midnight
    function automatic logic [SEC_WIDTH-1:0] to_seconds(input tsr_time_t t);
        return SEC_WIDTH'(t.hour) * SEC_WIDTH'(SEC_PER_HOUR)
             + SEC_WIDTH'(t.minute) * SEC_WIDTH'(SEC_PER_MIN)
             + SEC_WIDTH'(t.second);
    endfunction

    // relay level for the on/off window; units in range keep packed order
    function automatic logic in_window(input tsr_time_t now, input tsr_time_t on_t,
                                       input tsr_time_t off_t);
        logic [SEC_WIDTH-1:0] c;
        logic [SEC_WIDTH-1:0] a;
        logic [SEC_WIDTH-1:0] b;
        logic                 r;
        c = now;
        a = on_t;
        b = off_t;
        if (a <= b)
            r = (c >= a) && (c < b);
        else
            r = (c >= a) || (c < b);
        return r;
    endfunction

    // row or digit advance modulo three
    function automatic logic [1:0] next_sel(input logic [1:0] v);
        logic [2:0] s;
        s = {1'b0, v} + 3'd1;
        if (s >= {1'b0, SEL_COUNT}) s = s - {1'b0, SEL_COUNT};
        return s[1:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/tsr_in_if.sv -----
// ----------------------------------------------------------------------------
// tsr_in_if
// input channel: valid, ready and the transaction fields
// ----------------------------------------------------------------------------
`default_nettype none

interface tsr_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [2:0] key_number;
    logic [7:0] hour_value;
    logic [7:0] minute_value;
    logic [7:0] second_value;
    logic [2:0] field_present;
    logic       relay_request;

    modport source (
        output valid, kind, key_number, hour_value, minute_value, second_value,
               field_present, relay_request,
        input  ready
    );

    modport sink (
        input  valid, kind, key_number, hour_value, minute_value, second_value,
               field_present, relay_request,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/tsr_out_if.sv -----
// ----------------------------------------------------------------------------
// tsr_out_if
// result channel: valid, ready and the reported state
// ----------------------------------------------------------------------------
`default_nettype none

interface tsr_out_if;
    logic        valid;
    logic        ready;
    logic        relay_on;
    logic [2:0]  ui_mode;
    logic [1:0]  selected_row;
    logic [1:0]  selected_digit;
    logic [4:0]  now_hour;
    logic [5:0]  now_minute;
    logic [5:0]  now_second;
    logic [16:0] on_seconds_of_day;
    logic [16:0] off_seconds_of_day;
    logic        clock_write;

    modport source (
        output valid, relay_on, ui_mode, selected_row, selected_digit, now_hour,
               now_minute, now_second, on_seconds_of_day, off_seconds_of_day,
               clock_write,
        input  ready
    );

    modport sink (
        input  valid, relay_on, ui_mode, selected_row, selected_digit, now_hour,
               now_minute, now_second, on_seconds_of_day, off_seconds_of_day,
               clock_write,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/timer_socket_relay_controller.sv -----
// ----------------------------------------------------------------------------
// timer_socket_relay_controller
// relay controller for a time-of-day switched socket
// ----------------------------------------------------------------------------
//  channel  | role   | moves
//  ---------+--------+-----------------------------------------------
//  item     | sink   | key, tick, set-time or remote relay transaction
//  result   | source | relay, mode, selection and times after the step
//
// one transaction per cycle sustained while result.ready stays high; the path is
// the input register then the result register, the state loop closing through the step.
// reset (asynchronous, active low) empties both registers and loads main mode,
// relay off, 00:00:00 now, on at 08:00:00 and off at 22:00:00.
// while result.ready is low the result holds; one more transaction waits in
// the input register, after which item.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_socket_relay_controller (
    input  wire logic clk,
    input  wire logic rst_n,
    tsr_in_if.sink    item,
    tsr_out_if.source result
);

    logic                 held_valid;
    tsr_pkg::tsr_item_t   held_item;
    tsr_pkg::tsr_item_t   item_data;
    logic                 advance;
    tsr_pkg::tsr_state_t  state_reg;
    tsr_pkg::tsr_state_t  state_next;
    tsr_pkg::tsr_result_t step;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    tsr_pkg::tsr_result_t out_reg;

    // gather the input fields
    assign item_data = '{kind:          item.kind,
                         key_number:    item.key_number,
                         hour_value:    item.hour_value,
                         minute_value:  item.minute_value,
                         second_value:  item.second_value,
                         field_present: item.field_present,
                         relay_request: item.relay_request};

    tsr_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .item_data  (item_data),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    tsr_step u_step (
        .state  (state_reg),
        .item   (held_item),
        .result (step)
    );

    // a held transaction moves on when the result slot is free or draining
    assign advance = held_valid && (!out_valid_reg || result.ready);

    // controller state
    always_comb
    begin
        state_next = state_reg;
        if (advance)
            state_next = step.state;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode    <= tsr_pkg::MODE_MAIN;
            state_reg.relay   <= 1'b0;
            state_reg.row     <= tsr_pkg::ROW_CURRENT;
            state_reg.digit   <= tsr_pkg::DIGIT_HOUR;
            state_reg.now     <= '0;
            state_reg.on_time <= tsr_pkg::RESET_ON_TIME;
            state_reg.off_at  <= tsr_pkg::RESET_OFF_TIME;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // result register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= step;
    end

    assign result.valid              = out_valid_reg;
    assign result.relay_on           = out_reg.state.relay;
    assign result.ui_mode            = out_reg.state.mode;
    assign result.selected_row       = out_reg.state.row;
    assign result.selected_digit     = out_reg.state.digit;
    assign result.now_hour           = out_reg.state.now.hour;
    assign result.now_minute         = out_reg.state.now.minute;
    assign result.now_second         = out_reg.state.now.second;
    assign result.on_seconds_of_day  = out_reg.on_seconds;
    assign result.off_seconds_of_day = out_reg.off_seconds;
    assign result.clock_write        = out_reg.clock_write;

endmodule

`default_nettype wire

// ----- sv/tsr_in_reg.sv -----
// ----------------------------------------------------------------------------
// tsr_in_reg
// input register holding one transaction until the step logic takes it
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_in_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire tsr_pkg::tsr_item_t item_data,
    input  wire logic              advance,
    output logic                   held_valid,
    output tsr_pkg::tsr_item_t     held_item
);

    logic               valid_reg;
    logic               valid_next;
    tsr_pkg::tsr_item_t item_reg;

    // room when empty or when the held transaction moves on this cycle
    assign item_ready = !valid_reg || advance;

    // occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (item_valid && item_ready)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            item_reg <= item_data;
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

`default_nettype wire

// ----- sv/tsr_step.sv -----
// ----------------------------------------------------------------------------
// tsr_step
// next state of the controller for one transaction
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_step (
    input  wire tsr_pkg::tsr_state_t  state,
    input  wire tsr_pkg::tsr_item_t   item,
    output tsr_pkg::tsr_result_t      result
);

    tsr_pkg::tsr_state_t nxt;
    logic                clock_write;
    logic                up;

    // dispatch on kind and key
    always_comb
    begin
        nxt         = state;
        clock_write = 1'b0;
        up          = (item.key_number == tsr_pkg::KEY_4);
        unique case (tsr_pkg::kind_t'(item.kind))
            tsr_pkg::KIND_KEY:
            begin
                if (state.mode == tsr_pkg::MODE_TIMER)
                begin
                    unique case (item.key_number) inside
                        tsr_pkg::KEY_1: nxt.mode  = tsr_pkg::MODE_MAIN;
                        tsr_pkg::KEY_2: nxt.row   = tsr_pkg::next_sel(state.row);
                        tsr_pkg::KEY_3: nxt.digit = tsr_pkg::next_sel(state.digit);
                        tsr_pkg::KEY_4, tsr_pkg::KEY_5:
                        begin
                            case (state.row)
                                tsr_pkg::ROW_CURRENT:
                                begin
                                    nxt.now = tsr_pkg::step_time(state.now, state.digit, up);
                                    clock_write = 1'b1;
                                end
                                tsr_pkg::ROW_ON:
                                    nxt.on_time = tsr_pkg::step_time(state.on_time,
                                                                     state.digit, up);
                                tsr_pkg::ROW_OFF:
                                    nxt.off_at = tsr_pkg::step_time(state.off_at,
                                                                    state.digit, up);
                                default: ;
                            endcase
                            nxt.relay = tsr_pkg::in_window(nxt.now, nxt.on_time,
                                                           nxt.off_at);
                        end
                        default: ;
                    endcase
                end
                else
                begin
                    unique case (item.key_number)
                        tsr_pkg::KEY_1:
                        begin
                            nxt.mode  = tsr_pkg::MODE_TIMER;
                            nxt.row   = tsr_pkg::ROW_CURRENT;
                            nxt.digit = tsr_pkg::DIGIT_HOUR;
                            nxt.relay = tsr_pkg::in_window(state.now, state.on_time,
                                                           state.off_at);
                        end
                        tsr_pkg::KEY_2:
                        begin
                            if (state.mode == tsr_pkg::MODE_MAIN)
                                nxt.relay = !state.relay;
                            else
                                nxt.mode = tsr_pkg::MODE_MAIN;
                        end
                        tsr_pkg::KEY_3: nxt.mode = tsr_pkg::MODE_SSID;
                        tsr_pkg::KEY_4: nxt.mode = tsr_pkg::MODE_PASS;
                        tsr_pkg::KEY_5: nxt.mode = tsr_pkg::MODE_STATUS;
                        default: ;
                    endcase
                end
            end
            tsr_pkg::KIND_TICK:
            begin
                nxt.now.hour   = tsr_pkg::mod_hours(item.hour_value);
                nxt.now.minute = tsr_pkg::mod_sixty(item.minute_value);
                nxt.now.second = tsr_pkg::mod_sixty(item.second_value);
                if (state.mode == tsr_pkg::MODE_TIMER)
                    nxt.relay = tsr_pkg::in_window(nxt.now, state.on_time, state.off_at);
            end
            tsr_pkg::KIND_SET_NOW:
            begin
                nxt.now     = tsr_pkg::merge_units(state.now, item);
                clock_write = 1'b1;
            end
            tsr_pkg::KIND_SET_ON:
            begin
                nxt.on_time = tsr_pkg::merge_units(state.on_time, item);
                if (state.mode == tsr_pkg::MODE_TIMER)
                    nxt.relay = tsr_pkg::in_window(state.now, nxt.on_time, state.off_at);
            end
            tsr_pkg::KIND_SET_OFF:
            begin
                nxt.off_at = tsr_pkg::merge_units(state.off_at, item);
                if (state.mode == tsr_pkg::MODE_TIMER)
                    nxt.relay = tsr_pkg::in_window(state.now, state.on_time, nxt.off_at);
            end
            tsr_pkg::KIND_REMOTE:
            begin
                nxt.mode  = tsr_pkg::MODE_MAIN;
                nxt.relay = item.relay_request;
            end
            default: ;
        endcase
    end

    // reported values
    assign result.state       = nxt;
    assign result.clock_write = clock_write;
    assign result.on_seconds  = tsr_pkg::to_seconds(nxt.on_time);
    assign result.off_seconds = tsr_pkg::to_seconds(nxt.off_at);

endmodule

`default_nettype wire

// ----- sv/tsr_checker.sv -----
// ----------------------------------------------------------------------------
// tsr_checker
// port checks on the result channel of the relay controller
// ----------------------------------------------------------------------------
`default_nettype none

`include "timer_socket_relay_controller_defines.svh"

module tsr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        valid,
    input wire logic        ready,
    input wire logic        relay_on,
    input wire logic [2:0]  ui_mode,
    input wire logic [1:0]  selected_row,
    input wire logic [1:0]  selected_digit,
    input wire logic [4:0]  now_hour,
    input wire logic [5:0]  now_minute,
    input wire logic [5:0]  now_second,
    input wire logic [16:0] on_seconds_of_day,
    input wire logic [16:0] off_seconds_of_day,
    input wire logic        clock_write
);

    // a stalled result stays offered
    `TSR_ASSERT_NEXT(a_stall_holds_valid, clk, rst_n, valid && !ready, valid, "result dropped while stalled")

    // a stalled result keeps its relay, mode, on and off times and clock write
    `TSR_ASSERT_NEXT(a_stall_holds_data, clk, rst_n, valid && !ready, $stable(relay_on) && $stable(ui_mode) && $stable(on_seconds_of_day) && $stable(off_seconds_of_day) && $stable(clock_write), "result changed while stalled")

    // mode and selections stay within their codes
    `TSR_ASSERT_IMP(a_sel_range, clk, rst_n, valid, ui_mode <= 3'd4 && selected_row <= 2'd2 && selected_digit <= 2'd2, "mode or selection out of range")

    // all reported times are valid times of day
    `TSR_ASSERT_IMP(a_time_range, clk, rst_n, valid, now_hour <= 5'd23 && now_minute <= 6'd59 && now_second <= 6'd59 && on_seconds_of_day <= 17'd86399 && off_seconds_of_day <= 17'd86399, "time out of range")

endmodule

bind timer_socket_relay_controller tsr_checker u_tsr_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .valid              (result.valid),
    .ready              (result.ready),
    .relay_on           (result.relay_on),
    .ui_mode            (result.ui_mode),
    .selected_row       (result.selected_row),
    .selected_digit     (result.selected_digit),
    .now_hour           (result.now_hour),
    .now_minute         (result.now_minute),
    .now_second         (result.now_second),
    .on_seconds_of_day  (result.on_seconds_of_day),
    .off_seconds_of_day (result.off_seconds_of_day),
    .clock_write        (result.clock_write)
);

`default_nettype wire
